FILE: rtl/core/pixel_normalize_to_tensor_unit_assert.svh
// Assertion macros shared by the pixel normalizer RTL
`ifndef PIXEL_NORMALIZE_TO_TENSOR_UNIT_ASSERT_SVH
`define PIXEL_NORMALIZE_TO_TENSOR_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PNT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: ante -> cons");

// next-cycle implication, checked outside reset
`define PNT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: ante => cons");

`endif

FILE: rtl/core/pnt_pkg.sv
// Types, constants and codes shared by the pixel normalizer modules
package pnt_pkg;

  localparam int IN_TDATA_W   = 8;
  localparam int VALUE_W      = 26;
  localparam int INDEX_W      = 24;
  localparam int OUT_TDATA_W  = 56;
  localparam int MODE_W       = 3;
  localparam int PLANE_W      = 23;
  localparam int MEAN_W       = 16;
  localparam int SCALE_W      = 17;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 23;
  // wide enough for any effective plane size up to the parameter's top value
  localparam int PLANE_CALC_W = 25;
  localparam int DEF_MAX_PLANE_PIXELS = 4194304;

  typedef enum logic [MODE_W-1:0] {
    MODE_GRAY     = 3'd0,
    MODE_BGR_CHW  = 3'd1,
    MODE_BGR_HWC  = 3'd2,
    MODE_BGRA_CHW = 3'd3,
    MODE_BGRA_HWC = 3'd4
  } mode_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MODE       = 3'd0,
    REG_PLANE_SIZE = 3'd1,
    REG_MEAN_B     = 3'd2,
    REG_MEAN_G     = 3'd3,
    REG_MEAN_R     = 3'd4,
    REG_SCALE_B    = 3'd5,
    REG_SCALE_G    = 3'd6,
    REG_SCALE_R    = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CHAN_B     = 2'd0,
    CHAN_G     = 2'd1,
    CHAN_R     = 2'd2,
    CHAN_ALPHA = 2'd3
  } chan_t;

  typedef struct packed {
    mode_t               mode;
    logic [PLANE_W-1:0]  plane_size;
    logic [MEAN_W-1:0]   mean_b;
    logic [MEAN_W-1:0]   mean_g;
    logic [MEAN_W-1:0]   mean_r;
    logic [SCALE_W-1:0]  scale_b;
    logic [SCALE_W-1:0]  scale_g;
    logic [SCALE_W-1:0]  scale_r;
  } cfg_t;

  typedef struct packed {
    logic               emit;
    chan_t              chan;
    logic [INDEX_W-1:0] index;
    logic               last;
  } seq_t;

endpackage

FILE: rtl/core/pixel_normalize_to_tensor_unit.sv
// Pixel normalizer top level: input register, sequencer, datapath, result register
// An input byte passes through the input register and then the result register to out_tvalid.
// Throughput: one source byte per cycle while out_tready takes results; the input
// and result registers let a new byte enter while a finished result waits for out_tready.
// Alpha bytes and bytes taken in an unsupported mode give no result.
// Reset (rst_n low, synchronous) clears both stages, the byte phase and the
// pixel counter, and loads mode 1, plane size 1, means 0 and scales 1.0.
module pixel_normalize_to_tensor_unit
  import pnt_pkg::*;
#(
  parameter int MAX_PLANE_PIXELS = DEF_MAX_PLANE_PIXELS
)(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,    // [7:0] src_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,   // [25:0] out_value, [49:26] out_index, pad
  output logic                   out_tlast,   // frame_last
  input  logic                   cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wr_data
);

  `include "pixel_normalize_to_tensor_unit_assert.svh"

  cfg_t cfg;
  seq_t seq;
  logic signed [VALUE_W-1:0] value;

  logic                  s1_valid_r, s1_valid_nxt;
  logic [IN_TDATA_W-1:0] s1_byte_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]    out_value_r;
  logic [INDEX_W-1:0]    out_index_r;
  logic                  out_last_r;

  logic in_fire;
  logic s1_fire;
  logic out_free;

  pnt_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data),
    .cfg         (cfg)
  );

  pnt_seq #(
    .MAX_PLANE_PIXELS (MAX_PLANE_PIXELS)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .adv   (s1_fire),
    .seq   (seq)
  );

  pnt_norm u_norm (
    .cfg      (cfg),
    .chan     (seq.chan),
    .src_byte (s1_byte_r),
    .value    (value)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) s1_valid_nxt = 1'b1;
    else if (s1_fire) s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (s1_fire && seq.emit) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) s1_byte_r <= in_tdata;
    if (s1_fire && seq.emit) begin
      out_value_r <= value;
      out_index_r <= seq.index;
      out_last_r  <= seq.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-VALUE_W-INDEX_W){1'b0}}, out_index_r, out_value_r};
  assign out_tlast  = out_last_r;

  `PNT_ASSERT_NEXT(a_emit_loads_result, s1_fire && seq.emit, out_tvalid)
  `PNT_ASSERT_NOW(a_ready_when_result_empty, !out_valid_r, in_tready)
  `PNT_ASSERT_NEXT(a_dropped_byte_no_result, s1_fire && !seq.emit && out_valid_r, !out_tvalid)

endmodule

FILE: rtl/core/pnt_cfg_regs.sv
// Configuration register file of the pixel normalizer
module pnt_cfg_regs
  import pnt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_MODE:       cfg_nxt.mode       = mode_t'(cfg_wr_data[MODE_W-1:0]);
        REG_PLANE_SIZE: cfg_nxt.plane_size = cfg_wr_data[PLANE_W-1:0];
        REG_MEAN_B:     cfg_nxt.mean_b     = cfg_wr_data[MEAN_W-1:0];
        REG_MEAN_G:     cfg_nxt.mean_g     = cfg_wr_data[MEAN_W-1:0];
        REG_MEAN_R:     cfg_nxt.mean_r     = cfg_wr_data[MEAN_W-1:0];
        REG_SCALE_B:    cfg_nxt.scale_b    = cfg_wr_data[SCALE_W-1:0];
        REG_SCALE_G:    cfg_nxt.scale_g    = cfg_wr_data[SCALE_W-1:0];
        REG_SCALE_R:    cfg_nxt.scale_r    = cfg_wr_data[SCALE_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode       <= MODE_BGR_CHW;
      cfg_r.plane_size <= PLANE_W'(1);
      cfg_r.mean_b     <= '0;
      cfg_r.mean_g     <= '0;
      cfg_r.mean_r     <= '0;
      cfg_r.scale_b    <= SCALE_W'(65536);
      cfg_r.scale_g    <= SCALE_W'(65536);
      cfg_r.scale_r    <= SCALE_W'(65536);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/pnt_seq.sv
// Byte phase and pixel counter, channel select and tensor index
module pnt_seq
  import pnt_pkg::*;
#(
  parameter int MAX_PLANE_PIXELS = DEF_MAX_PLANE_PIXELS
)(
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic adv,
  output seq_t seq
);

  localparam int CNT_W = (MAX_PLANE_PIXELS > 1) ? $clog2(MAX_PLANE_PIXELS) : 1;
  localparam logic [PLANE_CALC_W-1:0] MAX_P = PLANE_CALC_W'(MAX_PLANE_PIXELS);
  localparam int IDX_CALC_W = PLANE_CALC_W + 2;

  logic [1:0]       phase_r, phase_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic [PLANE_CALC_W-1:0] plane_eff;
  logic [PLANE_CALC_W-1:0] pix;
  logic [PLANE_CALC_W-1:0] pix_inc;
  logic [PLANE_CALC_W-1:0] pix_next;
  logic                    last_pixel;
  logic [1:0]              phase;
  logic [1:0]              last_phase;
  logic                    planar;
  logic                    wrap;
  logic [IDX_CALC_W-1:0]   idx_calc;

  always_comb begin
    plane_eff = {{(PLANE_CALC_W-PLANE_W){1'b0}}, cfg.plane_size};
    if (plane_eff == '0) plane_eff = PLANE_CALC_W'(1);
    if (plane_eff > MAX_P) plane_eff = MAX_P;

    // count left past a shrunken plane restarts at zero
    pix = PLANE_CALC_W'(count_r);
    if (pix >= plane_eff) pix = '0;
    pix_inc    = pix + PLANE_CALC_W'(1);
    last_pixel = (pix_inc == plane_eff);
    pix_next   = last_pixel ? '0 : pix_inc;

    planar     = (cfg.mode == MODE_BGR_CHW) || (cfg.mode == MODE_BGRA_CHW);
    last_phase = ((cfg.mode == MODE_BGR_CHW) || (cfg.mode == MODE_BGR_HWC)) ? 2'd2 : 2'd3;
    phase      = phase_r;
    if (last_phase == 2'd2 && phase == 2'd3) phase = 2'd0;
    wrap       = (phase == last_phase);

    if (planar) begin
      case (phase)
        2'd0:    idx_calc = IDX_CALC_W'(pix);
        2'd1:    idx_calc = IDX_CALC_W'(plane_eff) + IDX_CALC_W'(pix);
        2'd2:    idx_calc = {1'b0, plane_eff, 1'b0} + IDX_CALC_W'(pix);
        default: idx_calc = '0;
      endcase
    end else begin
      idx_calc = {1'b0, pix, 1'b0} + IDX_CALC_W'(pix) + IDX_CALC_W'(phase);
    end

    phase_nxt = phase_r;
    count_nxt = count_r;
    seq.emit  = 1'b0;
    seq.chan  = CHAN_B;
    seq.index = '0;
    seq.last  = 1'b0;

    case (cfg.mode)
      MODE_GRAY: begin
        seq.emit  = 1'b1;
        seq.chan  = CHAN_B;
        seq.index = pix[INDEX_W-1:0];
        seq.last  = last_pixel;
        phase_nxt = 2'd0;
        count_nxt = CNT_W'(pix_next);
      end
      MODE_BGR_CHW, MODE_BGR_HWC, MODE_BGRA_CHW, MODE_BGRA_HWC: begin
        seq.emit  = (phase != 2'd3);
        seq.chan  = chan_t'(phase);
        seq.index = idx_calc[INDEX_W-1:0];
        seq.last  = last_pixel && (phase == 2'd2);
        phase_nxt = wrap ? 2'd0 : phase + 2'd1;
        count_nxt = wrap ? CNT_W'(pix_next) : CNT_W'(pix);
      end
      default: begin
        seq.emit  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      count_r <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

FILE: rtl/core/pnt_norm.sv
// Mean subtract and scale multiply for one channel byte
module pnt_norm
  import pnt_pkg::*;
(
  input  cfg_t                       cfg,
  input  chan_t                      chan,
  input  logic [IN_TDATA_W-1:0]      src_byte,
  output logic signed [VALUE_W-1:0]  value
);

  logic [MEAN_W-1:0]          mean;
  logic [SCALE_W-1:0]         scale;
  logic signed [MEAN_W+1:0]   diff;
  logic signed [MEAN_W+SCALE_W+2:0] prod;

  always_comb begin
    case (chan)
      CHAN_G: begin
        mean  = cfg.mean_g;
        scale = cfg.scale_g;
      end
      CHAN_R: begin
        mean  = cfg.mean_r;
        scale = cfg.scale_r;
      end
      default: begin
        mean  = cfg.mean_b;
        scale = cfg.scale_b;
      end
    endcase
  end

  // byte in Q8.8 minus mean, 18-bit signed
  assign diff = $signed({2'b00, src_byte, 8'h00}) - $signed({2'b00, mean});
  // both operands widened to the full product width before the multiply
  assign prod = $signed({{(SCALE_W+1){diff[MEAN_W+1]}}, diff}) *
                $signed({{(MEAN_W+3){1'b0}}, scale});
  // arithmetic shift by 8 then keep the low result bits
  assign value = prod[VALUE_W+7:8];

endmodule
